>>> design/nsc_pkg.sv
`default_nettype none

package nsc_pkg;

  // Framing characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] LOW7      = 8'h7F;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_BODY = 3'd1,
    PH_HEX1 = 3'd2,
    PH_HEX2 = 3'd3,
    PH_DONE = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOSTAR   = 3'd1,
    ST_BADHEX   = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_OVERLEN  = 3'd4
  } status_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] frame_length;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } result_word_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  // Decode one ASCII hex digit, upper or lower case
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok    = 1'b0;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok    = 1'b1;
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.ok    = 1'b1;
      h.value = 4'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.ok    = 1'b1;
      h.value = 4'(c - 8'h61 + 8'd10);
    end
    return h;
  endfunction

endpackage

`default_nettype wire

>>> design/nsc_tracker.sv
`default_nettype none

module nsc_tracker #(
  parameter int MAX_FRAME = 128
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire logic [7:0]            rx_byte,
  output nsc_pkg::result_word_t      result
);
  import nsc_pkg::*;

  localparam logic [7:0] MaxCount = 8'(MAX_FRAME);

  phase_t     phase, phase_next;
  logic [6:0] running_xor, running_xor_next;
  logic [3:0] high_nibble, high_nibble_next;
  status_t    pending_error, pending_error_next;
  logic [7:0] byte_count, byte_count_next;

  status_t    err_counted;
  logic [7:0] count_inc;
  hex_t       hex;
  logic [7:0] sum;

  // Advance sentence state for the word at the input register
  always_comb begin
    phase_next         = phase;
    running_xor_next   = running_xor;
    high_nibble_next   = high_nibble;
    pending_error_next = pending_error;
    byte_count_next    = byte_count;
    result.valid       = 1'b0;
    result.data.status = ST_OK;
    result.data.frame_length = byte_count;
    hex = hex_decode(rx_byte);
    sum = {high_nibble, hex.value};

    // Saturating length count; overrun latches the overlength status
    if (byte_count >= MaxCount) begin
      count_inc   = MaxCount;
      err_counted = ST_OVERLEN;
    end else begin
      count_inc   = byte_count + 8'd1;
      err_counted = pending_error;
    end

    if (rx_byte == CH_DOLLAR) begin
      phase_next         = PH_BODY;
      running_xor_next   = 7'd0;
      high_nibble_next   = 4'd0;
      pending_error_next = ST_OK;
      byte_count_next    = 8'd1;
    end else if (phase != PH_IDLE) begin
      byte_count_next    = count_inc;
      pending_error_next = err_counted;
      if (rx_byte == CH_LF) begin
        // Close the sentence and report
        result.valid = 1'b1;
        result.data.frame_length = count_inc;
        if (err_counted == ST_OVERLEN) begin
          result.data.status = ST_OVERLEN;
        end else if (phase == PH_BODY) begin
          result.data.status = ST_NOSTAR;
        end else if (phase == PH_HEX1 || phase == PH_HEX2) begin
          result.data.status = ST_BADHEX;
        end else begin
          result.data.status = err_counted;
        end
        phase_next         = PH_IDLE;
        running_xor_next   = 7'd0;
        high_nibble_next   = 4'd0;
        pending_error_next = ST_OK;
        byte_count_next    = 8'd0;
      end else begin
        unique case (phase)
          PH_BODY: begin
            if (rx_byte == CH_STAR) begin
              phase_next = PH_HEX1;
            end else begin
              running_xor_next = running_xor ^ rx_byte[6:0];
            end
          end
          PH_HEX1: begin
            if (!hex.ok) begin
              if (err_counted != ST_OVERLEN) pending_error_next = ST_BADHEX;
              phase_next = PH_DONE;
            end else begin
              high_nibble_next = hex.value;
              phase_next       = PH_HEX2;
            end
          end
          PH_HEX2: begin
            if (err_counted != ST_OVERLEN) begin
              if (!hex.ok) begin
                pending_error_next = ST_BADHEX;
              end else if (sum != {1'b0, running_xor}) begin
                pending_error_next = ST_MISMATCH;
              end
            end
            phase_next = PH_DONE;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Hold state between words
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      running_xor   <= 7'd0;
      high_nibble   <= 4'd0;
      pending_error <= ST_OK;
      byte_count    <= 8'd0;
    end else if (step) begin
      phase         <= phase_next;
      running_xor   <= running_xor_next;
      high_nibble   <= high_nibble_next;
      pending_error <= pending_error_next;
      byte_count    <= byte_count_next;
    end
  end

endmodule

`default_nettype wire

>>> design/nsc_out_reg.sv
`default_nettype none

module nsc_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire nsc_pkg::result_t load_data,
  output logic                  free,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [2:0]            status,
  output logic [7:0]            frame_length
);
  import nsc_pkg::*;

  logic    valid;
  result_t data;

  // Register may take a new word when empty or being drained
  assign free         = !valid || out_ready;
  assign out_valid    = valid;
  assign status       = data.status;
  assign frame_length = data.frame_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  // Capture the result word
  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

`default_nettype wire

>>> design/nmea_sentence_checksum_framer.sv
// NMEA sentence checksum framer.
// Input channel: rx_byte with in_valid/in_ready, one received character per word.
// Output channel: status and frame_length with out_valid/out_ready, one word per
// sentence closed by a line feed. Status: 0 ok, 1 no star, 2 bad hex digit,
// 3 checksum mismatch, 4 overlength (frame_length then saturates at MAX_FRAME).
// Path: a line feed accepted into the input register is processed from there
// and its result is loaded into the result register, which drives the outputs.
// Throughput: one character per cycle. The input register is processed at
// every edge unless it holds a line feed that closes a sentence while the
// result register is full and not being taken; then in_ready drops until
// out_ready frees the result register.
// Reset: synchronous, clears the input and result registers and leaves no
// sentence open; characters before the next '$' are dropped.
// Stall: results wait in the result register, payload held, until taken.

`default_nettype none

module nmea_sentence_checksum_framer #(
  parameter int MAX_FRAME = 128
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      status,
  output logic [7:0]      frame_length
);
  import nsc_pkg::*;

  logic         held;
  logic [7:0]   held_byte;
  logic         step;
  logic         out_free;
  result_word_t result;

  // Process the held word unless its result has nowhere to go
  assign step     = held && (!result.valid || out_free);
  assign in_ready = !held || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_byte <= rx_byte;
    end
  end

  nsc_tracker #(
    .MAX_FRAME(MAX_FRAME)
  ) u_tracker (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .rx_byte(held_byte),
    .result (result)
  );

  nsc_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (step && result.valid),
    .load_data   (result.data),
    .free        (out_free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .frame_length(frame_length)
  );

endmodule

`default_nettype wire

>>> dv/tb_nmea_sentence_checksum_framer.sv
module tb_nmea_sentence_checksum_framer;
  import nsc_pkg::*;

  localparam int MAX_FRAME  = 128;
  localparam int LIVE_WORDS = 1050;
  localparam int QUIET_FROM = 900;
  localparam int LONG_HOLD  = 300;
  localparam int PAUSE_AT   = 650;
  localparam int N_DIRECTED = 26;

  typedef struct packed {
    logic [7:0] ch;
    logic       typed;
    status_t    st;
    logic [7:0] len;
  } dir_row_t;

  // Hand-written opening sequence; typed rows carry the obvious result
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{8'hFF, 1'b0, ST_OK, 8'd0},        // noise before any sentence
    '{CH_LF, 1'b0, ST_OK, 8'd0},        // line feed with nothing open
    '{CH_DOLLAR, 1'b0, ST_OK, 8'd0},
    '{CH_LF, 1'b1, ST_NOSTAR, 8'd2},    // shortest sentence, no star
    '{CH_DOLLAR, 1'b0, ST_OK, 8'd0},
    '{CH_STAR, 1'b0, ST_OK, 8'd0},
    '{CH_LF, 1'b1, ST_BADHEX, 8'd3},    // line feed in place of a digit
    '{CH_DOLLAR, 1'b0, ST_OK, 8'd0},
    '{8'h6A, 1'b0, ST_OK, 8'd0},
    '{CH_STAR, 1'b0, ST_OK, 8'd0},
    '{8'h36, 1'b0, ST_OK, 8'd0},
    '{8'h61, 1'b0, ST_OK, 8'd0},        // lower case digit
    '{CH_LF, 1'b0, ST_OK, 8'd0},
    '{CH_DOLLAR, 1'b0, ST_OK, 8'd0},
    '{CH_STAR, 1'b0, ST_OK, 8'd0},
    '{8'h46, 1'b0, ST_OK, 8'd0},
    '{CH_DOLLAR, 1'b0, ST_OK, 8'd0},    // restart between the digits
    '{CH_STAR, 1'b0, ST_OK, 8'd0},
    '{8'h46, 1'b0, ST_OK, 8'd0},
    '{8'h67, 1'b0, ST_OK, 8'd0},        // not a hex digit
    '{CH_LF, 1'b1, ST_BADHEX, 8'd5},
    '{CH_DOLLAR, 1'b0, ST_OK, 8'd0},
    '{CH_STAR, 1'b0, ST_OK, 8'd0},
    '{8'h46, 1'b0, ST_OK, 8'd0},
    '{8'h46, 1'b0, ST_OK, 8'd0},        // checksum above 0x7F
    '{CH_LF, 1'b1, ST_MISMATCH, 8'd5}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [2:0] status;
  logic [7:0] frame_length;

  nmea_sentence_checksum_framer #(.MAX_FRAME(MAX_FRAME)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .frame_length (frame_length)
  );

  always #10 clk = ~clk;

  // Framer state as tracked by the testbench
  phase_t     fr_phase = PH_IDLE;
  logic [6:0] fr_sum   = '0;
  logic [3:0] fr_hi    = '0;
  status_t    fr_err   = ST_OK;
  logic [7:0] fr_count = '0;

  result_t awaited_results [$];
  int      fail_count = 0;
  int      live_words = 0;
  int      sent_words = 0;
  int      closed_frames = 0;
  int      per_status [5] = '{default: 0};
  bit      quiet = 1'b0;
  bit      hold_request = 1'b0;
  bit      hold_done = 1'b0;
  int      hold_left = 0;
  bit      paused_once = 1'b0;

  function automatic int hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "A" && c <= "F") return int'(c) - 55;
    if (c >= "a" && c <= "f") return int'(c) - 87;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  // Body byte: anything but the framing characters
  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_DOLLAR || b == CH_STAR || b == CH_LF);
    return b;
  endfunction

  function automatic logic [7:0] junk_byte(input bit no_hex);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_DOLLAR || b == CH_LF || (no_hex && hex_val(b) >= 0));
    return b;
  endfunction

  task automatic clear_frame();
    fr_phase = PH_IDLE;
    fr_sum   = '0;
    fr_hi    = '0;
    fr_err   = ST_OK;
    fr_count = '0;
  endtask

  // Advance the tracked framer by one accepted word
  task automatic track_byte(input logic [7:0] c, output bit live, output bit closed,
                            output result_t res);
    int v;
    live   = 1'b1;
    closed = 1'b0;
    res    = '0;
    if (c == CH_DOLLAR) begin
      clear_frame();
      fr_phase = PH_BODY;
      fr_count = 8'd1;
      return;
    end
    if (fr_phase == PH_IDLE) begin
      live = 1'b0;
      return;
    end
    if (fr_count >= MAX_FRAME) begin
      fr_count = 8'(MAX_FRAME);
      fr_err   = ST_OVERLEN;
    end else begin
      fr_count = fr_count + 8'd1;
    end
    if (c == CH_LF) begin
      closed = 1'b1;
      if (fr_err == ST_OVERLEN) res.status = ST_OVERLEN;
      else if (fr_phase == PH_BODY) res.status = ST_NOSTAR;
      else if (fr_phase == PH_HEX1 || fr_phase == PH_HEX2) res.status = ST_BADHEX;
      else res.status = fr_err;
      res.frame_length = fr_count;
      clear_frame();
      return;
    end
    v = hex_val(c);
    case (fr_phase)
      PH_BODY: begin
        if (c == CH_STAR) fr_phase = PH_HEX1;
        else fr_sum = fr_sum ^ c[6:0];
      end
      PH_HEX1: begin
        if (v < 0) begin
          if (fr_err != ST_OVERLEN) fr_err = ST_BADHEX;
          fr_phase = PH_DONE;
        end else begin
          fr_hi    = 4'(v);
          fr_phase = PH_HEX2;
        end
      end
      PH_HEX2: begin
        if (v < 0) begin
          if (fr_err != ST_OVERLEN) fr_err = ST_BADHEX;
        end else if ({fr_hi, 4'(v)} != {1'b0, fr_sum}) begin
          if (fr_err != ST_OVERLEN) fr_err = ST_MISMATCH;
        end
        fr_phase = PH_DONE;
      end
      default: ;
    endcase
  endtask

  // Offer one word from a falling edge, hold it until taken, log what it closes
  task automatic send_byte(input logic [7:0] b, input bit typed, input status_t tst,
                           input logic [7:0] tlen);
    bit      live;
    bit      closed;
    result_t res;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    track_byte(b, live, closed, res);
    sent_words++;
    if (live) live_words++;
    if (closed) begin
      if (typed) begin
        res.status       = tst;
        res.frame_length = tlen;
      end
      awaited_results.push_back(res);
    end
    @(negedge clk);
  endtask

  // Build one random line: mostly well formed, some broken, some noise
  task automatic send_sentence();
    logic [7:0] line [$];
    logic [7:0] ck;
    logic [7:0] b;
    logic [6:0] sum;
    int         kind;
    int         n;
    kind = $urandom_range(0, 99);
    if (kind >= 90) begin
      repeat ($urandom_range(1, 8)) line.push_back(8'($urandom_range(0, 255)));
    end else begin
      if (kind >= 84) begin
        // abandoned sentence, restarted by the next dollar
        line.push_back(CH_DOLLAR);
        repeat ($urandom_range(0, 6)) line.push_back(body_byte());
        if ($urandom_range(0, 1)) line.push_back(CH_STAR);
        if ($urandom_range(0, 1)) line.push_back(hex_char(4'($urandom_range(0, 15))));
      end
      n = ($urandom_range(0, 14) == 0) ? $urandom_range(118, 135) : $urandom_range(0, 20);
      sum = '0;
      line.push_back(CH_DOLLAR);
      repeat (n) begin
        b = body_byte();
        sum = sum ^ b[6:0];
        line.push_back(b);
      end
      if (kind >= 70 && kind < 76) begin
        line.push_back(CH_LF);
      end else begin
        line.push_back(CH_STAR);
        ck = {1'b0, sum};
        if (kind >= 60 && kind < 70) ck = ck ^ 8'($urandom_range(1, 255));
        if (kind >= 76 && kind < 80) begin
          if ($urandom_range(0, 1)) line.push_back(hex_char(ck[7:4]));
        end else begin
          if (kind >= 80 && kind < 84 && $urandom_range(0, 1)) line.push_back(junk_byte(1));
          else line.push_back(hex_char(ck[7:4]));
          if (kind >= 80 && kind < 84 && $urandom_range(0, 1)) line.push_back(junk_byte(1));
          else line.push_back(hex_char(ck[3:0]));
          if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) line.push_back(junk_byte(0));
        end
        line.push_back(CH_LF);
      end
    end
    foreach (line[i]) send_byte(line[i], 1'b0, ST_OK, 8'd0);
  endtask

  // Receiver: short random stalls, one long hold-off on request
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      hold_left <= $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Check each result word against the oldest awaited one
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      closed_frames++;
      if (status < 5) per_status[status]++;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result word, status %0d length %0d",
                 $time, status, frame_length);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        if (status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, status);
          fail_count++;
        end
        if (frame_length !== want.frame_length) begin
          $display("%0t: frame_length mismatch, expected %0d, actual %0d",
                   $time, want.frame_length, frame_length);
          fail_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    int guard;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      send_byte(DIRECTED[i].ch, DIRECTED[i].typed, DIRECTED[i].st, DIRECTED[i].len);

    while (live_words < LIVE_WORDS) begin
      if (live_words >= 400) hold_request = 1'b1;
      if (live_words >= QUIET_FROM) quiet = 1'b1;
      if (!paused_once && live_words >= PAUSE_AT) begin
        // hold the line until every sentence so far has been reported
        paused_once = 1'b1;
        in_valid <= 1'b0;
        @(negedge clk);
        while (awaited_results.size() != 0) @(negedge clk);
      end
      send_sentence();
    end
    in_valid <= 1'b0;

    // Drain, then allow for the two-stage latency
    guard = 0;
    while (awaited_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, awaited_results.size());
      fail_count += awaited_results.size();
    end

    $display("Sent %0d words (%0d inside sentences), checked %0d results.",
             sent_words, live_words, closed_frames);
    $display("Status ok/nostar/badhex/mismatch/overlen: %0d/%0d/%0d/%0d/%0d, failures %0d",
             per_status[0], per_status[1], per_status[2], per_status[3], per_status[4],
             fail_count);
    if (fail_count == 0) begin
      $display("tb_nmea_sentence_checksum_framer OK");
    end else begin
      $display("tb_nmea_sentence_checksum_framer NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10000000;
    $display("tb_nmea_sentence_checksum_framer NOT OK");
    $finish;
  end

endmodule

>>> files.f
design/nsc_pkg.sv
design/nsc_tracker.sv
design/nsc_out_reg.sv
design/nmea_sentence_checksum_framer.sv
dv/tb_nmea_sentence_checksum_framer.sv
